// ===== hw/rtl/sbus_frame_encoder_macros.svh =====
// assertion helpers for the asserting file sbus_frame_encoder.sv
`ifndef SBUS_FRAME_ENCODER_MACROS_SVH
`define SBUS_FRAME_ENCODER_MACROS_SVH

// same-cycle implication, off while reset is high
`define SFE_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sbus frame encoder check failed");

// next-cycle implication, off while reset is high
`define SFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sbus frame encoder check failed");

`endif

// ===== hw/rtl/sfe_pkg.sv =====
package sfe_pkg;

  // register indexes on the configuration port
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX = 2'd3;
  localparam int CFG_DATA_W = 12;

  // field widths
  localparam int VAL_W  = 12;
  localparam int CODE_W = 11;
  localparam int PROD_W = VAL_W + CODE_W;
  localparam int ACC_W  = 18;
  localparam int BITS_W = 5;
  localparam int BYTE_W = 8;

  // divider: quotient never exceeds the 11-bit code range
  localparam int DIV_STEPS = CODE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // fixed frame bytes
  localparam logic [BYTE_W-1:0] FRAME_HEADER     = 8'h0F;
  localparam logic [BYTE_W-1:0] FRAME_FOOTER     = 8'h00;
  localparam logic [BYTE_W-1:0] FLAG_SIGNAL_LOSS = 8'h04;
  localparam logic [BYTE_W-1:0] FLAG_FAILSAFE    = 8'h08;

  // which byte goes into the output register
  typedef enum logic [1:0] {
    SEL_HEADER = 2'd0,
    SEL_DATA   = 2'd1,
    SEL_FLAGS  = 2'd2,
    SEL_FOOTER = 2'd3
  } byte_sel_t;

  // commands from controller to datapath
  typedef struct packed {
    logic      load;
    logic      mul;
    logic      div_step;
    logic      pack;
    logic      emit;
    byte_sel_t sel;
    logic      idx_inc;
    logic      frame_clear;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic div_last;
    logic first_ch;
    logic last_ch;
    logic bits_ge8;
    logic out_free;
  } status_t;

endpackage

// ===== hw/rtl/sbus_frame_encoder.sv =====
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata[11:0] channel_value, [12] signal_loss,
//                                    [13] failsafe
// m_*       out  m_tvalid/m_tready   tdata[7:0] frame_byte, tlast last_of_frame
// cfg_*     in   cfg_wr              cfg_index register, cfg_data value
//
// each channel word goes through these steps with a free output: taking the
// word, one multiply, 11 restoring divider steps, then the header (first
// channel only), pack, each emitted byte, leaving the byte loop, and flags and
// footer after the last channel; the shared divider yields one bit a cycle.
// reset (rst, synchronous) restores the default ranges and empties the frame.
// a stalled output holds the sequencer in its current byte state; s_tready is high
// whenever the sequencer is idle, even while the last byte still waits.
`include "sbus_frame_encoder_macros.svh"

module sbus_frame_encoder #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [15:0]                    s_tdata,   // channel_value, signal_loss, failsafe
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,   // frame_byte
  output logic                           m_tlast
);

  sfe_pkg::cmd_t    cmd;
  sfe_pkg::status_t st;

  // sequencer
  sfe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  // mapping, divider, packing and output register
  sfe_datapath #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .st        (st)
  );

  // checks
  `SFE_ASSERT_NOW(a_last_is_footer, clk, rst, m_tvalid && m_tlast, m_tdata == sfe_pkg::FRAME_FOOTER)
  `SFE_ASSERT_NEXT(a_one_word_at_a_time, clk, rst, s_tvalid && s_tready, !s_tready)
  `SFE_ASSERT_NOW(a_idle_has_no_full_byte, clk, rst, s_tready, !st.bits_ge8)

endmodule

// ===== hw/rtl/sfe_datapath.sv =====
module sfe_datapath #(
  parameter int CHANNEL_COUNT = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr,
  input  logic [sfe_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sfe_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [15:0]                          s_tdata,
  input  logic                                 m_tready,
  output logic                                 m_tvalid,
  output logic [sfe_pkg::BYTE_W-1:0]           m_tdata,
  output logic                                 m_tlast,
  input  sfe_pkg::cmd_t                        cmd,
  output sfe_pkg::status_t                     st
);

  localparam int IDX_W = $clog2(CHANNEL_COUNT);

  // configuration registers
  logic [sfe_pkg::VAL_W-1:0]  in_min, in_max;
  logic [sfe_pkg::CODE_W-1:0] out_min, out_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_min  <= 12'd1000;
      in_max  <= 12'd2000;
      out_min <= 11'd173;
      out_max <= 11'd1811;
    end else if (cfg_wr) begin
      case (cfg_index)
        sfe_pkg::CFG_IN_MIN:  in_min  <= cfg_data;
        sfe_pkg::CFG_IN_MAX:  in_max  <= cfg_data;
        sfe_pkg::CFG_OUT_MIN: out_min <= cfg_data[sfe_pkg::CODE_W-1:0];
        sfe_pkg::CFG_OUT_MAX: out_max <= cfg_data[sfe_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp and offset of the incoming value
  logic [sfe_pkg::VAL_W-1:0] v_in, v_clamp;
  logic                      empty_in, neg_in;

  always_comb begin
    v_in     = s_tdata[sfe_pkg::VAL_W-1:0];
    empty_in = (in_max <= in_min);
    neg_in   = (out_max < out_min);
    if (v_in < in_min)      v_clamp = in_min;
    else if (v_in > in_max) v_clamp = in_max;
    else                    v_clamp = v_in;
  end

  // operand registers, loaded with the word
  logic [sfe_pkg::VAL_W-1:0]  d, span;
  logic [sfe_pkg::CODE_W-1:0] mag;
  logic                       neg, empty, loss, fs;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      d     <= v_clamp - in_min;
      span  <= in_max - in_min;
      mag   <= neg_in ? (out_min - out_max) : (out_max - out_min);
      neg   <= neg_in;
      empty <= empty_in;
      loss  <= s_tdata[12];
      fs    <= s_tdata[13];
    end
  end

  // product and restoring divider, one quotient bit a cycle
  logic [sfe_pkg::PROD_W-1:0]    prod;
  logic [sfe_pkg::VAL_W-1:0]     rem;
  logic [sfe_pkg::CODE_W-1:0]    dq;
  logic [sfe_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [sfe_pkg::VAL_W:0]       trial;
  logic                          q_bit;

  assign prod  = {{(sfe_pkg::CODE_W){1'b0}}, d} * {{(sfe_pkg::VAL_W){1'b0}}, mag};
  assign trial = {rem, dq[sfe_pkg::CODE_W-1]};
  assign q_bit = (trial >= {1'b0, span});

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem     <= prod[sfe_pkg::PROD_W-1:sfe_pkg::CODE_W];
      dq      <= prod[sfe_pkg::CODE_W-1:0];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= q_bit ? sfe_pkg::VAL_W'(trial - {1'b0, span})
                       : trial[sfe_pkg::VAL_W-1:0];
      dq      <= {dq[sfe_pkg::CODE_W-2:0], q_bit};
      div_cnt <= div_cnt + 1'b1;
    end
  end

  // final code with sign and offset
  logic [sfe_pkg::CODE_W-1:0] code;

  always_comb begin
    if (empty)    code = out_min;
    else if (neg) code = out_min - dq;
    else          code = out_min + dq;
  end

  // bit accumulator and channel position
  logic [sfe_pkg::ACC_W-1:0]  acc;
  logic [sfe_pkg::BITS_W-1:0] bits_held;
  logic [IDX_W-1:0]           idx;
  logic                       take_data;

  assign take_data = cmd.emit && (cmd.sel == sfe_pkg::SEL_DATA);

  always_ff @(posedge clk) begin
    if (rst || cmd.frame_clear) begin
      acc       <= '0;
      bits_held <= '0;
      idx       <= '0;
    end else begin
      if (cmd.pack) begin
        acc       <= acc | ({{(sfe_pkg::ACC_W-sfe_pkg::CODE_W){1'b0}}, code}
                            << bits_held[2:0]);
        bits_held <= {2'b00, bits_held[2:0]} + 5'd11;
      end else if (take_data) begin
        acc       <= acc >> sfe_pkg::BYTE_W;
        bits_held <= bits_held - 5'd8;
      end
      if (cmd.idx_inc) idx <= idx + 1'b1;
    end
  end

  // output register
  logic [sfe_pkg::BYTE_W-1:0] byte_mux, flags;

  always_comb begin
    flags = (loss ? sfe_pkg::FLAG_SIGNAL_LOSS : 8'h00) |
            (fs ? sfe_pkg::FLAG_FAILSAFE : 8'h00);
    case (cmd.sel)
      sfe_pkg::SEL_HEADER: byte_mux = sfe_pkg::FRAME_HEADER;
      sfe_pkg::SEL_DATA:   byte_mux = acc[sfe_pkg::BYTE_W-1:0];
      sfe_pkg::SEL_FLAGS:  byte_mux = flags;
      sfe_pkg::SEL_FOOTER: byte_mux = sfe_pkg::FRAME_FOOTER;
      default:             byte_mux = sfe_pkg::FRAME_FOOTER;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= byte_mux;
      m_tlast <= (cmd.sel == sfe_pkg::SEL_FOOTER);
    end
  end

  // status back to the controller
  always_comb begin
    st.div_last = (div_cnt == sfe_pkg::DIV_CNT_W'(sfe_pkg::DIV_STEPS - 1));
    st.first_ch = (idx == '0);
    st.last_ch  = (idx == IDX_W'(CHANNEL_COUNT - 1));
    st.bits_ge8 = (bits_held >= 5'd8);
    st.out_free = !m_tvalid || m_tready;
  end

endmodule

// ===== hw/rtl/sfe_ctrl.sv =====
module sfe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  sfe_pkg::status_t st,
  output sfe_pkg::cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_HDR  = 8'b0000_1000,
    S_PACK = 8'b0001_0000,
    S_DATA = 8'b0010_0000,
    S_FLAG = 8'b0100_0000,
    S_FOOT = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.sel         = sfe_pkg::SEL_DATA;
    s_tready        = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) state_next = S_HDR;
      end
      S_HDR: begin
        if (!st.first_ch) begin
          state_next = S_PACK;
        end else if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = sfe_pkg::SEL_HEADER;
          state_next = S_PACK;
        end
      end
      S_PACK: begin
        cmd.pack   = 1'b1;
        state_next = S_DATA;
      end
      S_DATA: begin
        if (st.bits_ge8) begin
          if (st.out_free) begin
            cmd.emit = 1'b1;
            cmd.sel  = sfe_pkg::SEL_DATA;
          end
        end else if (st.last_ch) begin
          state_next = S_FLAG;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_IDLE;
        end
      end
      S_FLAG: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          cmd.sel    = sfe_pkg::SEL_FLAGS;
          state_next = S_FOOT;
        end
      end
      S_FOOT: begin
        if (st.out_free) begin
          cmd.emit        = 1'b1;
          cmd.sel         = sfe_pkg::SEL_FOOTER;
          cmd.frame_clear = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== bench/sbus_frame_encoder_tb.sv =====
module sbus_frame_encoder_tb;

  localparam int CHANNEL_COUNT = 16;
  localparam int STALL_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_of_frame;
  } sbus_byte_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_wr = 1'b0;
  logic [sfe_pkg::CFG_IDX_W-1:0]  cfg_index = sfe_pkg::CFG_IN_MIN;
  logic [sfe_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [15:0]                    s_tdata = '0;   // channel_value, signal_loss, failsafe
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [7:0]                     m_tdata;         // frame_byte
  logic                           m_tlast;

  sbus_frame_encoder #(.CHANNEL_COUNT(CHANNEL_COUNT)) uut (
    .clk(clk), .rst(rst),
    .cfg_wr(cfg_wr), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow of the range registers and the packer state
  int          raw_lo  = 1000;
  int          raw_hi  = 2000;
  int          code_lo = 173;
  int          code_hi = 1811;
  logic [17:0] pack_bits;
  logic [4:0]  pack_count;
  logic [3:0]  chan_pos;

  logic [15:0] channel_words[$];
  sbus_byte_t  frame_bytes_due[$];
  int          words_queued = 0;
  int          words_taken = 0;
  int          fault_count = 0;
  int          stall_cycles = 0;
  logic        steady = 1'b0;
  logic        word_taken = 1'b0;

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  // clamp and linear rescale onto the sbus code range
  function automatic logic [10:0] scale_channel(input logic [11:0] raw);
    longint x;
    longint q;
    if (raw_hi <= raw_lo) return code_lo[10:0];
    x = raw;
    if (x < raw_lo) x = raw_lo;
    if (x > raw_hi) x = raw_hi;
    q = (x - raw_lo) * longint'(code_hi - code_lo) / longint'(raw_hi - raw_lo) + code_lo;
    return q[10:0];
  endfunction

  // expected bytes for one accepted channel word
  task automatic encode_channel(input logic [15:0] word);
    logic [10:0] code;
    logic [7:0]  flags;
    code = scale_channel(word[11:0]);
    if (chan_pos == 4'd0) frame_bytes_due.push_back('{sfe_pkg::FRAME_HEADER, 1'b0});
    pack_bits = pack_bits | (18'(code) << pack_count[2:0]);
    pack_count = pack_count[2:0] + 5'd11;
    while (pack_count >= 5'd8) begin
      frame_bytes_due.push_back('{pack_bits[7:0], 1'b0});
      pack_bits = pack_bits >> 8;
      pack_count = pack_count - 5'd8;
    end
    if (chan_pos == 4'(CHANNEL_COUNT - 1)) begin
      flags = '0;
      if (word[12]) flags = flags | sfe_pkg::FLAG_SIGNAL_LOSS;
      if (word[13]) flags = flags | sfe_pkg::FLAG_FAILSAFE;
      frame_bytes_due.push_back('{flags, 1'b0});
      frame_bytes_due.push_back('{sfe_pkg::FRAME_FOOTER, 1'b1});
      pack_bits = '0;
      pack_count = '0;
      chan_pos = '0;
    end else begin
      chan_pos = chan_pos + 4'd1;
    end
  endtask

  // input driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (channel_words.size() > 0 && (steady || $urandom_range(0, 99) >= 20)) begin
        s_tdata <= channel_words.pop_front();
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output back-pressure
  always @(negedge clk) begin
    m_tready <= steady || $urandom_range(0, 99) >= 20;
  end

  // accept words, predict, and check bytes
  always @(posedge clk) begin
    sbus_byte_t want;
    if (rst) begin
      word_taken <= 1'b0;
      pack_bits = '0;
      pack_count = '0;
      chan_pos = '0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (frame_bytes_due.size() == 0) begin
          report_fault($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
        end else begin
          want = frame_bytes_due.pop_front();
          if (m_tdata !== want.frame_byte || m_tlast !== want.last_of_frame)
            report_fault($sformatf("byte mismatch: expected %02h last %0b, got %02h last %0b",
                                   want.frame_byte, want.last_of_frame, m_tdata, m_tlast));
        end
      end
      word_taken <= s_tvalid && s_tready;
      if (s_tvalid && s_tready) begin
        words_taken++;
        encode_channel(s_tdata);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("sbus_frame_encoder regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // write all four range registers, block must be idle
  task automatic set_ranges(input int lo, input int hi, input int c_lo, input int c_hi);
    int vals[4];
    logic [sfe_pkg::CFG_IDX_W-1:0] regs[4];
    vals = '{lo, hi, c_lo, c_hi};
    regs = '{sfe_pkg::CFG_IN_MIN, sfe_pkg::CFG_IN_MAX,
             sfe_pkg::CFG_OUT_MIN, sfe_pkg::CFG_OUT_MAX};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_wr <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i][sfe_pkg::CFG_DATA_W-1:0];
    end
    @(negedge clk);
    cfg_wr <= 1'b0;
    raw_lo = lo;
    raw_hi = hi;
    code_lo = c_lo;
    code_hi = c_hi;
  endtask

  // one frame of random channel words; flag_mode 0..3 fixes the flags, 4 randomizes
  task automatic queue_frame(input int flag_mode);
    int v;
    logic loss;
    logic fs;
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      case ($urandom_range(0, 3))
        0: v = $urandom_range(0, 4095);
        1: v = (raw_lo < raw_hi) ? $urandom_range(raw_lo, raw_hi) : $urandom_range(0, 4095);
        2: v = raw_lo + $urandom_range(0, 6) - 3;
        default: v = raw_hi + $urandom_range(0, 6) - 3;
      endcase
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      loss = $urandom_range(0, 1);
      fs = $urandom_range(0, 1);
      if (ch == CHANNEL_COUNT - 1 && flag_mode < 4) begin
        loss = flag_mode[0];
        fs = flag_mode[1];
      end
      channel_words.push_back({2'b00, fs, loss, v[11:0]});
      words_queued++;
    end
  endtask

  // wait for every word and byte, then let the block settle
  task automatic drain;
    while (words_taken != words_queued || frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // stimulus
  initial begin
    int dir_vals[16];
    int lo;
    int hi;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default ranges: bounds, just outside, mid-scale and field extremes
    dir_vals = '{0, 4095, 999, 1000, 1001, 1500, 1999, 2000,
                 2001, 2047, 2048, 1024, 4094, 1, 1234, 3000};
    for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
      channel_words.push_back({2'b00, 1'b1, 1'b1, dir_vals[ch][11:0]});
      words_queued++;
    end
    drain();

    // full input and output span, no idling on either side
    set_ranges(0, 4095, 0, 2047);
    steady = 1'b1;
    queue_frame(1);
    queue_frame(4);
    drain();
    steady = 1'b0;

    // descending output: negative numerator, truncation toward zero
    set_ranges(100, 3000, 2047, 0);
    queue_frame(2);
    queue_frame(4);
    drain();

    // empty input range, equal bounds
    set_ranges(2000, 2000, 5, 900);
    queue_frame(0);
    drain();

    // empty input range, reversed bounds
    set_ranges(4095, 1, 2047, 2047);
    queue_frame(4);
    drain();

    // narrowest input span
    set_ranges(0, 1, 0, 2047);
    queue_frame(4);
    drain();

    // random ranges, mostly well formed
    for (int p = 0; p < 3; p++) begin
      lo = $urandom_range(0, 3000);
      hi = ($urandom_range(0, 1) == 1) ? lo + $urandom_range(1, 8)
                                       : lo + $urandom_range(1, 4095 - lo);
      set_ranges(lo, hi, $urandom_range(0, 2047), $urandom_range(0, 2047));
      queue_frame(4);
      drain();
    end

    if (fault_count == 0) begin
      $display("sbus_frame_encoder regression: pass");
    end else begin
      $display("sbus_frame_encoder regression: fail");
    end
    $finish;
  end

endmodule
